// File: src/i2c_master_transfer_sequencer_core_defines.svh
// Assertion macros shared by the checker.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, quiet in reset
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet in reset
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/i2cms_pkg.sv
`timescale 1ns / 1ps
package i2cms_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_EVENT = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_BUSY    = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  // bus status codes, after masking
  localparam logic [7:0] SC_MASK     = 8'hF8;
  localparam logic [7:0] SC_START    = 8'h08;
  localparam logic [7:0] SC_RSTART   = 8'h10;
  localparam logic [7:0] SC_ADDR_ACK = 8'h18;
  localparam logic [7:0] SC_ADDR_ALT = 8'h40;
  localparam logic [7:0] SC_DATA_ACK = 8'h28;
  localparam logic [7:0] SC_RX_ACK   = 8'h50;
  localparam logic [7:0] SC_RX_NACK  = 8'h58;

  typedef struct packed {
    status_t     transfer_status;
    logic        start_refused;
    logic        control_write;
    logic        control_start;
    logic        control_stop;
    logic        control_ack;
    logic        control_irq;
    logic        data_write;
    logic [7:0]  data_out;
    logic        read_valid;
    logic [7:0]  read_index;
    logic [7:0]  read_byte;
    logic        use_ram;     // data_out comes from the write buffer read
  } res_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } ram_req_t;

endpackage

// File: src/i2cms_ram.sv
`timescale 1ns / 1ps
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/i2cms_ctrl.sv
`timescale 1ns / 1ps
module i2cms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [6:0]        chip_address,
  input  logic              read_direction,
  input  logic [8:0]        transfer_length,
  input  logic [7:0]        buffer_index,
  input  logic [7:0]        buffer_byte,
  input  logic [7:0]        status_code,
  input  logic [7:0]        received_byte,
  output i2cms_pkg::res_t     res,
  output i2cms_pkg::ram_req_t ram_req
);
  import i2cms_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_ADDRESS = 3'd2,
    PH_WRITE   = 3'd3,
    PH_READ    = 3'd4
  } phase_t;

  localparam logic [8:0] LEN_CAP = 9'(BUFFER_DEPTH);

  phase_t     phase_r, phase_nxt;
  logic       dir_r, dir_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [8:0] len_r, len_nxt;
  logic [8:0] cnt_r, cnt_nxt;
  status_t    status_r, status_nxt;

  always_comb begin
    logic [7:0] code;
    logic       do_write;
    logic [9:0] cnt_inc;
    code       = status_code & SC_MASK;
    do_write   = 1'b0;
    cnt_inc    = {1'b0, cnt_r} + 10'd1;
    phase_nxt  = phase_r;
    dir_nxt    = dir_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    res        = '0;
    ram_req    = '0;
    ram_req.waddr = BUF_AW'(buffer_index);
    ram_req.wdata = buffer_byte;
    ram_req.raddr = cnt_r[BUF_AW-1:0];

    if (accept) begin
      unique case (action)
        ACT_START: begin
          if (phase_r != PH_IDLE) begin
            res.start_refused = 1'b1;
          end else begin
            addr_nxt   = chip_address;
            dir_nxt    = read_direction;
            len_nxt    = (int'(transfer_length) > BUFFER_DEPTH) ? LEN_CAP : transfer_length;
            cnt_nxt    = '0;
            status_nxt = ST_BUSY;
            phase_nxt  = PH_START;
            res.control_write = 1'b1;
            res.control_start = 1'b1;
            res.control_irq   = 1'b1;
          end
        end
        ACT_LOAD: begin
          ram_req.we = (int'(buffer_index) < BUFFER_DEPTH);
        end
        ACT_EVENT: begin
          unique case (phase_r)
            PH_START: begin
              if (code == SC_START || code == SC_RSTART) begin
                res.data_write    = 1'b1;
                res.data_out      = {addr_r, dir_r};
                res.control_write = 1'b1;
                res.control_irq   = 1'b1;
                phase_nxt         = PH_ADDRESS;
              end else begin
                status_nxt = ST_ERROR;
                phase_nxt  = PH_IDLE;
              end
            end
            PH_ADDRESS: begin
              if (code == SC_ADDR_ACK || code == SC_ADDR_ALT) begin
                if (dir_r) begin
                  res.control_write = 1'b1;
                  res.control_irq   = 1'b1;
                  res.control_ack   = (len_r > 9'd1);
                  phase_nxt         = PH_READ;
                end else begin
                  do_write = 1'b1;
                end
              end else begin
                res.control_write = 1'b1;
                res.control_stop  = 1'b1;
                status_nxt        = ST_ERROR;
                phase_nxt         = PH_IDLE;
              end
            end
            PH_WRITE: begin
              if (code == SC_DATA_ACK) begin
                do_write = 1'b1;
              end else begin
                res.control_write = 1'b1;
                res.control_stop  = 1'b1;
                status_nxt        = ST_ERROR;
                phase_nxt         = PH_IDLE;
              end
            end
            PH_READ: begin
              if (code == SC_RX_ACK || code == SC_RX_NACK) begin
                res.read_valid = 1'b1;
                res.read_index = cnt_r[7:0];
                res.read_byte  = received_byte;
                cnt_nxt        = cnt_inc[8:0];
                res.control_write = 1'b1;
                if (cnt_inc < {1'b0, len_r}) begin
                  res.control_irq = 1'b1;
                  res.control_ack = ((cnt_inc + 10'd1) < {1'b0, len_r});
                end else begin
                  res.control_stop = 1'b1;
                  status_nxt       = ST_SUCCESS;
                  phase_nxt        = PH_IDLE;
                end
              end else begin
                res.control_write = 1'b1;
                res.control_stop  = 1'b1;
                status_nxt        = ST_ERROR;
                phase_nxt         = PH_IDLE;
              end
            end
            default: begin
              // idle: event ignored
            end
          endcase
        end
        default: begin
          // unused action: ignored
        end
      endcase

      // next write byte, or stop once the length is used up
      if (do_write) begin
        res.control_write = 1'b1;
        if (cnt_r < len_r) begin
          res.data_write  = 1'b1;
          res.use_ram     = 1'b1;
          res.control_irq = 1'b1;
          ram_req.re      = 1'b1;
          cnt_nxt         = cnt_inc[8:0];
          phase_nxt       = PH_WRITE;
        end else begin
          res.control_stop = 1'b1;
          status_nxt       = ST_SUCCESS;
          phase_nxt        = PH_IDLE;
        end
      end
    end

    res.transfer_status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      dir_r    <= 1'b0;
      addr_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      status_r <= ST_SUCCESS;
    end else begin
      phase_r  <= phase_nxt;
      dir_r    <= dir_nxt;
      addr_r   <= addr_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// File: src/i2c_master_transfer_sequencer_core.sv
// I2C master transfer sequencer. Each input item starts a transfer, loads one
// write-buffer byte or reports a bus status event, and gives exactly one result
// item with the control word, the byte to send, any captured read byte and the
// transfer status. One item is accepted every clock cycle unless both stages
// are full and out_ready is low. A result passes through stage 1, which takes
// the registered write-buffer RAM read, and then the output register. A result
// waiting on out_ready does not stop the next item from entering the read
// stage. The write buffer has no reset and no clearing pass: sending a slot
// that was never loaded gives an undefined byte.
`timescale 1ns / 1ps
module i2c_master_transfer_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [6:0] in_chip_address,
  input  logic       in_read_direction,
  input  logic [8:0] in_transfer_length,
  input  logic [7:0] in_buffer_index,
  input  logic [7:0] in_buffer_byte,
  input  logic [7:0] in_status_code,
  input  logic [7:0] in_received_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_transfer_status,
  output logic       out_start_refused,
  output logic       out_control_write,
  output logic       out_control_start,
  output logic       out_control_stop,
  output logic       out_control_ack,
  output logic       out_control_irq,
  output logic       out_data_write,
  output logic [7:0] out_data_out,
  output logic       out_read_valid,
  output logic [7:0] out_read_index,
  output logic [7:0] out_read_byte
);
  import i2cms_pkg::*;

  logic     in_accept;
  res_t     res;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;

  // stage 1: item decided, buffer read in flight
  logic s1_v_r;
  res_t s1_r;
  logic s1_adv;
  // stage 2: output register
  logic out_v_r;
  res_t out_r;

  assign s1_adv    = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || !out_v_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Phase, counters and status update at accept; the buffer read issued there
  // returns in stage 1. A load lands in the RAM at its own accept edge, so any
  // later event already reads the new byte: no forwarding needed.
  i2cms_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .action          (in_action),
    .chip_address    (in_chip_address),
    .read_direction  (in_read_direction),
    .transfer_length (in_transfer_length),
    .buffer_index    (in_buffer_index),
    .buffer_byte     (in_buffer_byte),
    .status_code     (in_status_code),
    .received_byte   (in_received_byte),
    .res             (res),
    .ram_req         (ram_req)
  );

  // Read is enabled only at accept, so rdata holds while stage 1 stalls.
  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= res;
    end
    if (s1_adv) begin
      out_r <= s1_r;
      if (s1_r.use_ram) begin
        out_r.data_out <= ram_rdata;
      end
    end
  end

  assign out_valid           = out_v_r;
  assign out_transfer_status = out_r.transfer_status;
  assign out_start_refused   = out_r.start_refused;
  assign out_control_write   = out_r.control_write;
  assign out_control_start   = out_r.control_start;
  assign out_control_stop    = out_r.control_stop;
  assign out_control_ack     = out_r.control_ack;
  assign out_control_irq     = out_r.control_irq;
  assign out_data_write      = out_r.data_write;
  assign out_data_out        = out_r.data_out;
  assign out_read_valid      = out_r.read_valid;
  assign out_read_index      = out_r.read_index;
  assign out_read_byte       = out_r.read_byte;

endmodule

// File: src/i2cms_checker.sv
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_core_defines.svh"
module i2cms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [1:0] out_transfer_status,
  input logic       out_start_refused,
  input logic       out_control_write,
  input logic       out_control_start,
  input logic       out_control_stop,
  input logic       out_control_ack,
  input logic       out_control_irq,
  input logic       out_data_write,
  input logic [7:0] out_data_out,
  input logic       out_read_valid,
  input logic [7:0] out_read_index,
  input logic [7:0] out_read_byte
);
  import i2cms_pkg::*;

  // fields behind a low strobe read as zero
  `I2CMS_ASSERT_NOW(a_strobe_zero, out_valid,
    (out_control_write ||
     !(out_control_start || out_control_stop || out_control_ack || out_control_irq)) &&
    (out_data_write || out_data_out == 8'd0) &&
    (out_read_valid || (out_read_index == 8'd0 && out_read_byte == 8'd0)),
    "field set behind a low strobe")
  // a refused start only happens mid-transfer
  `I2CMS_ASSERT_NOW(a_refused_busy, out_valid && out_start_refused,
    out_transfer_status == ST_BUSY && !out_control_write, "refused start not busy")
  // a start condition opens a transfer
  `I2CMS_ASSERT_NOW(a_start_busy, out_valid && out_control_start,
    out_transfer_status == ST_BUSY && !out_control_stop, "start without busy")
  // a stop condition always closes it
  `I2CMS_ASSERT_NOW(a_stop_done, out_valid && out_control_stop,
    out_transfer_status != ST_BUSY && !out_data_write, "stop leaves transfer busy")

endmodule

bind i2c_master_transfer_sequencer_core i2cms_checker u_i2cms_checker (.*);

// File: bench/tb_i2c_master_transfer_sequencer_core.sv
`timescale 1ns / 1ps
module tb_i2c_master_transfer_sequencer_core;
  import i2cms_pkg::*;

  // Action code that the block has no use for; it must pass through untouched.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Masked status of zero matches no phase: ends any transfer, ignored when idle.
  localparam logic [7:0] SC_NONE = 8'h00;

  // One input item, one field per port.
  typedef struct packed {
    logic [1:0] action;
    logic [6:0] chip_address;
    logic       read_direction;
    logic [8:0] transfer_length;
    logic [7:0] buffer_index;
    logic [7:0] buffer_byte;
    logic [7:0] status_code;
    logic [7:0] received_byte;
  } bus_item_t;

  // One result item, as the output ports carry it.
  typedef struct packed {
    status_t    transfer_status;
    logic       start_refused;
    logic       control_write;
    logic       control_start;
    logic       control_stop;
    logic       control_ack;
    logic       control_irq;
    logic       data_write;
    logic [7:0] data_out;
    logic       read_valid;
    logic [7:0] read_index;
    logic [7:0] read_byte;
  } xfer_result_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_ADDR,
    SEQ_WRITE,
    SEQ_READ
  } seq_phase_t;

  // Which acknowledge a bus event stands for inside a transfer.
  typedef enum logic [1:0] {
    EV_START,
    EV_ADDR,
    EV_DATA,
    EV_RX
  } ev_kind_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_transfer_status;
  logic       out_start_refused;
  logic       out_control_write;
  logic       out_control_start;
  logic       out_control_stop;
  logic       out_control_ack;
  logic       out_control_irq;
  logic       out_data_write;
  logic [7:0] out_data_out;
  logic       out_read_valid;
  logic [7:0] out_read_index;
  logic [7:0] out_read_byte;

  bus_item_t drv_item = '0;

  i2c_master_transfer_sequencer_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (drv_item.action),
    .in_chip_address     (drv_item.chip_address),
    .in_read_direction   (drv_item.read_direction),
    .in_transfer_length  (drv_item.transfer_length),
    .in_buffer_index     (drv_item.buffer_index),
    .in_buffer_byte      (drv_item.buffer_byte),
    .in_status_code      (drv_item.status_code),
    .in_received_byte    (drv_item.received_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_transfer_status (out_transfer_status),
    .out_start_refused   (out_start_refused),
    .out_control_write   (out_control_write),
    .out_control_start   (out_control_start),
    .out_control_stop    (out_control_stop),
    .out_control_ack     (out_control_ack),
    .out_control_irq     (out_control_irq),
    .out_data_write      (out_data_write),
    .out_data_out        (out_data_out),
    .out_read_valid      (out_read_valid),
    .out_read_index      (out_read_index),
    .out_read_byte       (out_read_byte)
  );

  // Items waiting to be driven, results waiting to come out.
  bus_item_t    bus_items_q[$];
  xfer_result_t due_results_q[$];
  int           stim_total  = 0;
  int           items_taken = 0;
  int           mismatches  = 0;

  // Slots the stimulus has loaded so far; a write transfer never reaches past them.
  bit slot_loaded [BUFFER_DEPTH];

  // Predictor state: our own copy of the sequencer.
  seq_phase_t seq_phase   = SEQ_IDLE;
  logic       xfer_read   = 1'b0;
  logic [6:0] xfer_addr   = '0;
  logic [8:0] xfer_len    = '0;
  logic [8:0] xfer_count  = '0;
  status_t    xfer_status = ST_SUCCESS;
  logic [7:0] wbuf [BUFFER_DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Control word to the bus engine; start strobe is set by the caller.
  function automatic void set_ctl(inout xfer_result_t r, input logic stp, input logic ack,
                                  input logic irq);
    r.control_write = 1'b1;
    r.control_stop  = stp;
    r.control_ack   = ack;
    r.control_irq   = irq;
  endfunction

  function automatic void end_transfer(input status_t st);
    xfer_status = st;
    seq_phase   = SEQ_IDLE;
  endfunction

  function automatic void abort_with_stop(inout xfer_result_t r);
    set_ctl(r, 1'b1, 1'b0, 1'b0);
    end_transfer(ST_ERROR);
  endfunction

  // Next write byte, or stop and success once the held length has gone out.
  function automatic void send_next_byte(inout xfer_result_t r);
    if (xfer_count < xfer_len) begin
      r.data_write = 1'b1;
      r.data_out   = wbuf[xfer_count[7:0]];
      xfer_count   = xfer_count + 9'd1;
      set_ctl(r, 1'b0, 1'b0, 1'b1);
    end else begin
      set_ctl(r, 1'b1, 1'b0, 1'b0);
      end_transfer(ST_SUCCESS);
    end
  endfunction

  function automatic xfer_result_t step_transfer(input bus_item_t it);
    xfer_result_t r;
    logic [7:0]   code;
    r = '0;
    case (it.action)
      ACT_START: begin
        if (seq_phase != SEQ_IDLE) begin
          r.start_refused = 1'b1;
        end else begin
          xfer_addr   = it.chip_address;
          xfer_read   = it.read_direction;
          xfer_len    = (it.transfer_length > BUFFER_DEPTH) ? 9'(BUFFER_DEPTH)
                                                           : it.transfer_length;
          xfer_count  = '0;
          xfer_status = ST_BUSY;
          seq_phase   = SEQ_START;
          set_ctl(r, 1'b0, 1'b0, 1'b1);
          r.control_start = 1'b1;
        end
      end
      ACT_LOAD: wbuf[it.buffer_index] = it.buffer_byte;
      ACT_EVENT: begin
        code = it.status_code & SC_MASK;
        case (seq_phase)
          SEQ_START: begin
            if (code == SC_START || code == SC_RSTART) begin
              r.data_write = 1'b1;
              r.data_out   = {xfer_addr, xfer_read};
              set_ctl(r, 1'b0, 1'b0, 1'b1);
              seq_phase = SEQ_ADDR;
            end else begin
              // no control word when the start itself fails
              end_transfer(ST_ERROR);
            end
          end
          SEQ_ADDR: begin
            // either acknowledge code is taken whatever the direction
            if (code == SC_ADDR_ACK || code == SC_ADDR_ALT) begin
              if (xfer_read) begin
                set_ctl(r, 1'b0, xfer_len > 9'd1, 1'b1);
                seq_phase = SEQ_READ;
              end else begin
                seq_phase = SEQ_WRITE;
                send_next_byte(r);
              end
            end else begin
              abort_with_stop(r);
            end
          end
          SEQ_WRITE: begin
            if (code == SC_DATA_ACK) send_next_byte(r);
            else abort_with_stop(r);
          end
          SEQ_READ: begin
            if (code == SC_RX_ACK || code == SC_RX_NACK) begin
              // a zero-length read still captures one byte
              r.read_valid = 1'b1;
              r.read_index = xfer_count[7:0];
              r.read_byte  = it.received_byte;
              xfer_count   = xfer_count + 9'd1;
              if (xfer_count < xfer_len) begin
                set_ctl(r, 1'b0, (xfer_count + 9'd1) < xfer_len, 1'b1);
              end else begin
                set_ctl(r, 1'b1, 1'b0, 1'b0);
                end_transfer(ST_SUCCESS);
              end
            end else begin
              abort_with_stop(r);
            end
          end
          default: ; // idle: event ignored
        endcase
      end
      default: ; // unused action
    endcase
    r.transfer_status = xfer_status;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic bus_item_t random_item();
    bus_item_t it;
    it.action          = 2'($urandom_range(3));
    it.chip_address    = 7'($urandom_range(127));
    it.read_direction  = 1'($urandom_range(1));
    it.transfer_length = 9'($urandom_range(511));
    it.buffer_index    = 8'($urandom_range(255));
    it.buffer_byte     = 8'($urandom_range(255));
    it.status_code     = 8'($urandom_range(255));
    it.received_byte   = 8'($urandom_range(255));
    return it;
  endfunction

  // Queues an item. Any start in the write direction gets its slots loaded first,
  // whether or not the block will take it, so an unloaded slot is never sent.
  task automatic push_item(input bus_item_t it);
    bus_item_t ld;
    int        n;
    if (it.action == ACT_START && !it.read_direction) begin
      n = (it.transfer_length > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(it.transfer_length);
      for (int i = 0; i < n; i++) begin
        if (!slot_loaded[i]) begin
          ld              = random_item();
          ld.action       = ACT_LOAD;
          ld.buffer_index = 8'(i);
          bus_items_q.push_back(ld);
          slot_loaded[i] = 1'b1;
        end
      end
    end
    if (it.action == ACT_LOAD) slot_loaded[it.buffer_index] = 1'b1;
    bus_items_q.push_back(it);
  endtask

  task automatic push_start(input logic [6:0] addr, input logic rd, input logic [8:0] len);
    bus_item_t it;
    it                 = random_item();
    it.action          = ACT_START;
    it.chip_address    = addr;
    it.read_direction  = rd;
    it.transfer_length = len;
    push_item(it);
  endtask

  // Bus event of the given kind; junk low bits check the masking. A bad event
  // carries any code that does not fit where the transfer stands.
  task automatic push_event(input ev_kind_t kind, input bit bad);
    bus_item_t  it;
    logic [7:0] base, alt, code;
    case (kind)
      EV_START: begin base = SC_START;    alt = SC_RSTART;   end
      EV_ADDR:  begin base = SC_ADDR_ACK; alt = SC_ADDR_ALT; end
      EV_DATA:  begin base = SC_DATA_ACK; alt = SC_DATA_ACK; end
      default:  begin base = SC_RX_ACK;   alt = SC_RX_NACK;  end
    endcase
    if (bad) begin
      code = 8'($urandom_range(255));
      while ((code & SC_MASK) == base || (code & SC_MASK) == alt)
        code = 8'($urandom_range(255));
    end else begin
      code = ($urandom_range(1) ? base : alt) | 8'($urandom_range(7));
    end
    it             = random_item();
    it.action      = ACT_EVENT;
    it.status_code = code;
    push_item(it);
  endtask

  // Drags the block back to idle from wherever noise left it.
  task automatic push_flush();
    bus_item_t it;
    it             = random_item();
    it.action      = ACT_EVENT;
    it.status_code = SC_NONE | 8'($urandom_range(7));
    push_item(it);
  endtask

  // Something that must not disturb a transfer in flight: a load, a refused
  // start or the unused action.
  task automatic push_distraction();
    bus_item_t it;
    it = random_item();
    case ($urandom_range(2))
      0:       it.action = ACT_LOAD;
      1:       it.action = ACT_START;
      default: it.action = ACT_UNUSED;
    endcase
    push_item(it);
  endtask

  // Whole transfer from idle back to idle; a broken one gets a wrong code at a
  // random step and ends there with an error.
  task automatic add_transfer(input bit rd, input int len, input bit broken);
    int eff, n_steps, break_at;
    eff      = (len > BUFFER_DEPTH) ? BUFFER_DEPTH : len;
    n_steps  = 2 + (rd ? ((eff == 0) ? 1 : eff) : eff + 1);
    break_at = broken ? $urandom_range(n_steps - 1) : n_steps;
    push_start(7'($urandom_range(127)), rd, 9'(len));
    for (int s = 0; s < n_steps; s++) begin
      if (s > 0 && $urandom_range(9) == 0) push_distraction();
      push_event((s == 0) ? EV_START : (s == 1) ? EV_ADDR : (rd ? EV_RX : EV_DATA),
                 s == break_at);
      if (s == break_at) break;
    end
  endtask

  // Mostly short transfers; now and then a long one, rarely past the buffer.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 2) return $urandom_range(511);
    if (r < 15) return $urandom_range(40);
    return $urandom_range(6);
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shaping: sender/receiver idle rates swap over a third of the way
  // in, and the last third runs flat out with one long receiver hold-off.
  // ---------------------------------------------------------------------------

  function automatic int traffic_mode();
    if (items_taken * 3 < stim_total) return 0;
    if (items_taken * 3 < stim_total * 2) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (traffic_mode())
      0:       return 22;
      1:       return 77;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (traffic_mode())
      0:       return 77;
      1:       return 22;
      default: return 0;
    endcase
  endfunction

  // Driver: a new item goes up once the current one is taken (or none is up).
  // The prediction is made at the edge that accepts the item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        due_results_q.push_back(step_transfer(drv_item));
        items_taken++;
      end
      if (bus_items_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        drv_item <= bus_items_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off so the block's
  // pipeline fills and in_ready has to drop while the sender keeps offering.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && traffic_mode() == 2 && items_taken * 6 > stim_total * 5) begin
      hold_done = 1'b1;
      hold_left = 90;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Monitor samples mid-cycle: a result seen with valid and ready high here is
  // the one taken at the next rising edge, and all pushes to the expectation
  // queue happened on earlier edges.
  always @(negedge clk) begin
    xfer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = due_results_q.pop_front();
        check_field("transfer_status", 8'(out_transfer_status), 8'(want.transfer_status));
        check_field("start_refused",   8'(out_start_refused),   8'(want.start_refused));
        check_field("control_write",   8'(out_control_write),   8'(want.control_write));
        check_field("control_start",   8'(out_control_start),   8'(want.control_start));
        check_field("control_stop",    8'(out_control_stop),    8'(want.control_stop));
        check_field("control_ack",     8'(out_control_ack),     8'(want.control_ack));
        check_field("control_irq",     8'(out_control_irq),     8'(want.control_irq));
        check_field("data_write",      8'(out_data_write),      8'(want.data_write));
        check_field("data_out",        out_data_out,            want.data_out);
        check_field("read_valid",      8'(out_read_valid),      8'(want.read_valid));
        check_field("read_index",      out_read_index,          want.read_index);
        check_field("read_byte",       out_read_byte,           want.read_byte);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    bus_item_t it;
    int        n_directed;
    int        r;

    // Directed: event while idle and the unused action, both ignored.
    push_event(EV_START, 1'b0);
    it        = random_item();
    it.action = ACT_UNUSED;
    push_item(it);
    // All-ones byte in slot 0; the write below loads slot 1 on its own.
    it              = random_item();
    it.action       = ACT_LOAD;
    it.buffer_index = 8'd0;
    it.buffer_byte  = 8'hFF;
    push_item(it);
    // Top address, two-byte write, with a start refused while busy.
    push_start(7'h7F, 1'b0, 9'd2);
    push_event(EV_START, 1'b0);
    push_start(7'h00, 1'b1, 9'd0);
    push_event(EV_ADDR, 1'b0);
    push_event(EV_DATA, 1'b0);
    push_event(EV_DATA, 1'b0);
    push_event(EV_DATA, 1'b0);
    // Zero-length write: address acknowledge ends it with stop.
    push_start(7'h00, 1'b0, 9'd0);
    push_event(EV_START, 1'b0);
    push_event(EV_ADDR, 1'b0);
    // Zero-length read: still one byte captured.
    push_start(7'h55, 1'b1, 9'd0);
    push_event(EV_START, 1'b0);
    push_event(EV_ADDR, 1'b0);
    push_event(EV_RX, 1'b0);
    // Length beyond the buffer, then a wrong code in the start phase.
    push_start(7'h2A, 1'b1, 9'd511);
    push_event(EV_START, 1'b1);
    // Wrong code after the address went out.
    push_start(7'h01, 1'b1, 9'd3);
    push_event(EV_START, 1'b0);
    push_event(EV_ADDR, 1'b1);
    n_directed = bus_items_q.size();

    // Random: mostly clean transfers, some broken, some raw noise.
    while (bus_items_q.size() < n_directed + 1150) begin
      r = $urandom_range(99);
      if (r < 70) begin
        add_transfer($urandom_range(1), pick_length(), 1'b0);
      end else if (r < 85) begin
        add_transfer($urandom_range(1), pick_length(), 1'b1);
      end else begin
        repeat ($urandom_range(6, 1)) push_item(random_item());
        push_flush();
      end
    end
    stim_total = bus_items_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < stim_total || due_results_q.size() != 0) @(posedge clk);
    // anything extra showing up now is a failure
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/i2cms_pkg.sv
src/i2cms_ram.sv
src/i2cms_ctrl.sv
src/i2c_master_transfer_sequencer_core.sv
src/i2cms_checker.sv
bench/tb_i2c_master_transfer_sequencer_core.sv
